FILE: rtl/core/cgcs_pkg.sv
// ----------------------------------------------------------------------------
// cgcs_pkg: shared definitions of the charge grid cluster summary
// Widths, register codes, reset values, sequencer states and the structs that
// travel between the blocks of the design.
// ----------------------------------------------------------------------------
package cgcs_pkg;

  localparam int CHARGE_W    = 12;
  localparam int IDX_W       = 3;
  localparam int BOARD_W     = 2;
  localparam int PITCH_W     = 16;
  localparam int TOTAL_W     = 18;
  localparam int FIRED_W     = 7;
  localparam int MOMENT_W    = 40;
  localparam int CENT_W      = 15;
  localparam int PROD_W      = 32;
  localparam int MUL_A_W     = 28;
  localparam int DIVIDEND_W  = MOMENT_W - 5;
  localparam int DIV_CNT_W   = $clog2(CENT_W + 1);
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 18;

  // Grid size; positions at or beyond it are ignored.
  localparam int GRID_ROWS = 8;
  localparam int GRID_COLS = 8;

  localparam logic [FIRED_W-1:0] FIRED_MAX = '1;

  // Configuration reset values.
  localparam logic [CHARGE_W-1:0] RST_FIRE_THRESHOLD   = 12'd10;
  localparam logic [PITCH_W-1:0]  RST_PITCH_ROW        = 16'd4864;
  localparam logic [PITCH_W-1:0]  RST_PITCH_COL        = 16'd6484;
  localparam logic [TOTAL_W-1:0]  RST_MUON_CHARGE_LOW  = 18'd4000;
  localparam logic [TOTAL_W-1:0]  RST_MUON_CHARGE_HIGH = 18'd4400;
  localparam logic [FIRED_W-1:0]  RST_MUON_FIRED_LOW   = 7'd4;
  localparam logic [FIRED_W-1:0]  RST_MUON_FIRED_HIGH  = 7'd7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FIRE_THRESHOLD   = 3'd0,
    CFG_PITCH_ROW        = 3'd1,
    CFG_PITCH_COL        = 3'd2,
    CFG_MUON_CHARGE_LOW  = 3'd3,
    CFG_MUON_CHARGE_HIGH = 3'd4,
    CFG_MUON_FIRED_LOW   = 3'd5,
    CFG_MUON_FIRED_HIGH  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [CHARGE_W-1:0] fire_threshold;
    logic [PITCH_W-1:0]  pitch_row;
    logic [PITCH_W-1:0]  pitch_col;
    logic [TOTAL_W-1:0]  muon_charge_low;
    logic [TOTAL_W-1:0]  muon_charge_high;
    logic [FIRED_W-1:0]  muon_fired_low;
    logic [FIRED_W-1:0]  muon_fired_high;
  } cfg_regs_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [TOTAL_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CENT_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_PITCH,
    ST_MUL_POS,
    ST_ACCUM,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/core/cgcs_in_if.sv
// ----------------------------------------------------------------------------
// cgcs_in_if: channel charge input channel
// Valid/ready channel carrying one grid channel charge and its event tags.
// ----------------------------------------------------------------------------
interface cgcs_in_if;
  logic                          valid;
  logic                          ready;
  logic [cgcs_pkg::CHARGE_W-1:0] charge;
  logic [cgcs_pkg::IDX_W-1:0]    row;
  logic [cgcs_pkg::IDX_W-1:0]    col;
  logic                          last_channel;
  logic [cgcs_pkg::BOARD_W-1:0]  board_ok;
  logic                          timestamp_error;

  modport source (
    output valid, charge, row, col, last_channel, board_ok, timestamp_error,
    input  ready
  );
  modport sink (
    input  valid, charge, row, col, last_channel, board_ok, timestamp_error,
    output ready
  );
endinterface

FILE: rtl/core/cgcs_out_if.sv
// ----------------------------------------------------------------------------
// cgcs_out_if: event summary output channel
// Valid/ready channel carrying one summary per closed event.
// ----------------------------------------------------------------------------
interface cgcs_out_if;
  logic                          valid;
  logic                          ready;
  logic [cgcs_pkg::BOARD_W-1:0]  event_type;
  logic                          event_good;
  logic [cgcs_pkg::FIRED_W-1:0]  fired_count;
  logic [cgcs_pkg::TOTAL_W-1:0]  total_charge;
  logic [cgcs_pkg::CHARGE_W-1:0] max_charge;
  logic [cgcs_pkg::IDX_W-1:0]    max_row;
  logic [cgcs_pkg::IDX_W-1:0]    max_col;
  logic [cgcs_pkg::CENT_W-1:0]   centroid_row;
  logic [cgcs_pkg::CENT_W-1:0]   centroid_col;
  logic                          muon_candidate;

  modport source (
    output valid, event_type, event_good, fired_count, total_charge, max_charge,
           max_row, max_col, centroid_row, centroid_col, muon_candidate,
    input  ready
  );
  modport sink (
    input  valid, event_type, event_good, fired_count, total_charge, max_charge,
           max_row, max_col, centroid_row, centroid_col, muon_candidate,
    output ready
  );
endinterface

FILE: rtl/core/cgcs_cfg_if.sv
// ----------------------------------------------------------------------------
// cgcs_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface cgcs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cgcs_pkg::CFG_INDEX_W-1:0] index;
  logic [cgcs_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/cgcs_cfg_regs.sv
// ----------------------------------------------------------------------------
// cgcs_cfg_regs: configuration register file
// Holds the threshold, pitches and muon window limits; writes to an index
// beyond the register list are dropped.
// ----------------------------------------------------------------------------
module cgcs_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  cgcs_cfg_if.sink            cfg_ch,
  output cgcs_pkg::cfg_regs_t regs_o
);

  cgcs_pkg::cfg_regs_t regs_r;
  cgcs_pkg::cfg_regs_t regs_nxt;

  assign cfg_ch.ready = 1'b1;
  assign regs_o       = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_ch.valid) begin
      case (cgcs_pkg::cfg_idx_t'(cfg_ch.index))
        cgcs_pkg::CFG_FIRE_THRESHOLD:
          regs_nxt.fire_threshold = cfg_ch.data[cgcs_pkg::CHARGE_W-1:0];
        cgcs_pkg::CFG_PITCH_ROW:
          regs_nxt.pitch_row = cfg_ch.data[cgcs_pkg::PITCH_W-1:0];
        cgcs_pkg::CFG_PITCH_COL:
          regs_nxt.pitch_col = cfg_ch.data[cgcs_pkg::PITCH_W-1:0];
        cgcs_pkg::CFG_MUON_CHARGE_LOW:
          regs_nxt.muon_charge_low = cfg_ch.data[cgcs_pkg::TOTAL_W-1:0];
        cgcs_pkg::CFG_MUON_CHARGE_HIGH:
          regs_nxt.muon_charge_high = cfg_ch.data[cgcs_pkg::TOTAL_W-1:0];
        cgcs_pkg::CFG_MUON_FIRED_LOW:
          regs_nxt.muon_fired_low = cfg_ch.data[cgcs_pkg::FIRED_W-1:0];
        cgcs_pkg::CFG_MUON_FIRED_HIGH:
          regs_nxt.muon_fired_high = cfg_ch.data[cgcs_pkg::FIRED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.fire_threshold   <= cgcs_pkg::RST_FIRE_THRESHOLD;
      regs_r.pitch_row        <= cgcs_pkg::RST_PITCH_ROW;
      regs_r.pitch_col        <= cgcs_pkg::RST_PITCH_COL;
      regs_r.muon_charge_low  <= cgcs_pkg::RST_MUON_CHARGE_LOW;
      regs_r.muon_charge_high <= cgcs_pkg::RST_MUON_CHARGE_HIGH;
      regs_r.muon_fired_low   <= cgcs_pkg::RST_MUON_FIRED_LOW;
      regs_r.muon_fired_high  <= cgcs_pkg::RST_MUON_FIRED_HIGH;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

FILE: rtl/core/cgcs_mul.sv
// ----------------------------------------------------------------------------
// cgcs_mul: shared registered multiplier
// One multiplier used for both the pitch product and the position weight of
// both axes; the product is registered before any further use.
// ----------------------------------------------------------------------------
module cgcs_mul (
  input  logic                          clk,
  input  logic                          en_i,
  input  logic [cgcs_pkg::MUL_A_W-1:0]  a_i,
  input  logic [cgcs_pkg::PITCH_W-1:0]  b_i,
  output logic [cgcs_pkg::PROD_W-1:0]   p_o
);

  logic [cgcs_pkg::MUL_A_W+cgcs_pkg::PITCH_W-1:0] full;
  logic [cgcs_pkg::PROD_W-1:0]                     p_r;

  // The moment term never exceeds 32 bits, so the upper bits are always zero.
  assign full = a_i * b_i;
  assign p_o  = p_r;

  always_ff @(posedge clk) begin
    if (en_i) begin
      p_r <= full[cgcs_pkg::PROD_W-1:0];
    end
  end

endmodule

FILE: rtl/core/cgcs_div.sv
// ----------------------------------------------------------------------------
// cgcs_div: radix-2 restoring divider for the centroid
// Divides a moment (already scaled by 1/32) by the total charge, one quotient
// bit per cycle, with saturation and a zero divisor handled at start.
// ----------------------------------------------------------------------------
module cgcs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  cgcs_pkg::div_req_t req_i,
  output cgcs_pkg::div_rsp_t rsp_o
);

  localparam int HI_W = cgcs_pkg::DIVIDEND_W - cgcs_pkg::CENT_W;

  logic                            busy_r;
  logic                            done_r;
  logic [cgcs_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [cgcs_pkg::TOTAL_W-1:0]    rem_r;
  logic [cgcs_pkg::TOTAL_W-1:0]    d_r;
  logic [cgcs_pkg::CENT_W-1:0]     lo_r;
  logic [cgcs_pkg::CENT_W-1:0]     q_r;

  logic [HI_W-1:0]                 hi;
  logic                            sat;
  logic [cgcs_pkg::TOTAL_W:0]      trial;
  logic [cgcs_pkg::TOTAL_W:0]      diff;
  logic                            ge;

  // When the upper dividend bits reach the divisor the quotient needs more
  // than fifteen bits and saturates.
  assign hi    = req_i.dividend[cgcs_pkg::DIVIDEND_W-1:cgcs_pkg::CENT_W];
  assign sat   = hi >= HI_W'(req_i.divisor);
  assign trial = {rem_r, lo_r[cgcs_pkg::CENT_W-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = trial >= {1'b0, d_r};

  assign rsp_o.done = done_r;
  assign rsp_o.quot = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        if (req_i.divisor == '0) begin
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else if (sat) begin
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= cgcs_pkg::DIV_CNT_W'(cgcs_pkg::CENT_W);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == cgcs_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.start) begin
      d_r   <= req_i.divisor;
      rem_r <= hi[cgcs_pkg::TOTAL_W-1:0];
      lo_r  <= req_i.dividend[cgcs_pkg::CENT_W-1:0];
      if (req_i.divisor == '0) begin
        q_r <= '0;
      end else if (sat) begin
        q_r <= '1;
      end else begin
        q_r <= '0;
      end
    end else if (busy_r) begin
      rem_r <= ge ? diff[cgcs_pkg::TOTAL_W-1:0] : trial[cgcs_pkg::TOTAL_W-1:0];
      lo_r  <= {lo_r[cgcs_pkg::CENT_W-2:0], 1'b0};
      q_r   <= {q_r[cgcs_pkg::CENT_W-2:0], ge};
    end
  end

endmodule

FILE: rtl/core/charge_grid_cluster_summary.sv
// ----------------------------------------------------------------------------
// charge_grid_cluster_summary: cluster summary for a grid of sensor channels
// Accumulates fired count, total charge, pitch-weighted moments and the first
// maximum over an event, and emits one summary with centroids per event.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake     Transaction content
//   in_ch    in   valid/ready   charge, row, col, last_channel, board_ok,
//                               timestamp_error
//   out_ch   out  valid/ready   event summary (type, good, sums, max, centroids,
//                               muon flag)
//   cfg_ch   in   valid/ready   register index and write data, always ready
//
// A non-last channel below threshold or outside the grid leaves the block in
// idle. For a fired channel the one shared multiplier forms charge * pitch and
// then the position weight, once for each axis, before each moment is added.
// The last channel adds an emit step, and a good event also the two centroid
// divisions before it, which share one radix-2 divider: a start step, fifteen
// bit steps and a done step each, or only start and done when the total is zero
// or the quotient saturates. The emit step repeats while the previous summary
// still waits in the output register.
// Reset is synchronous and active low; it clears all accumulators and loads
// the configuration defaults. A stalled output holds its summary in the output
// register; the block keeps accepting channels until the next summary is due.
//
module charge_grid_cluster_summary (
  input  logic       clk,
  input  logic       rst_n,
  cgcs_in_if.sink    in_ch,
  cgcs_out_if.source out_ch,
  cgcs_cfg_if.sink   cfg_ch
);

  cgcs_pkg::cfg_regs_t cfg;
  cgcs_pkg::state_t    state_r;
  cgcs_pkg::state_t    state_nxt;

  // Latched channel transaction.
  logic [cgcs_pkg::CHARGE_W-1:0] charge_r;
  logic [cgcs_pkg::IDX_W-1:0]    row_r;
  logic [cgcs_pkg::IDX_W-1:0]    col_r;
  logic                          last_r;
  logic [cgcs_pkg::BOARD_W-1:0]  board_r;
  logic                          ts_err_r;

  // Axis select: 0 works on rows, 1 on columns (moments and centroids).
  logic axis_r;
  logic axis_nxt;

  // Event accumulators.
  logic [cgcs_pkg::FIRED_W-1:0]  fired_acc_r,    fired_acc_nxt;
  logic [cgcs_pkg::TOTAL_W-1:0]  charge_acc_r,   charge_acc_nxt;
  logic [cgcs_pkg::MOMENT_W-1:0] row_mom_r,      row_mom_nxt;
  logic [cgcs_pkg::MOMENT_W-1:0] col_mom_r,      col_mom_nxt;
  logic [cgcs_pkg::CHARGE_W-1:0] max_seen_r,     max_seen_nxt;
  logic [cgcs_pkg::IDX_W-1:0]    max_row_r,      max_row_nxt;
  logic [cgcs_pkg::IDX_W-1:0]    max_col_r,      max_col_nxt;
  logic [cgcs_pkg::CENT_W-1:0]   cent_row_r;
  logic [cgcs_pkg::CENT_W-1:0]   cent_col_r;

  // Output register.
  logic                          out_valid_r;
  logic [cgcs_pkg::BOARD_W-1:0]  o_type_r;
  logic                          o_good_r;
  logic [cgcs_pkg::FIRED_W-1:0]  o_fired_r;
  logic [cgcs_pkg::TOTAL_W-1:0]  o_total_r;
  logic [cgcs_pkg::CHARGE_W-1:0] o_max_r;
  logic [cgcs_pkg::IDX_W-1:0]    o_max_row_r;
  logic [cgcs_pkg::IDX_W-1:0]    o_max_col_r;
  logic [cgcs_pkg::CENT_W-1:0]   o_cent_row_r;
  logic [cgcs_pkg::CENT_W-1:0]   o_cent_col_r;
  logic                          o_muon_r;

  // Sequencer outputs.
  logic                          in_take;
  logic                          mul_en;
  logic [cgcs_pkg::MUL_A_W-1:0]  mul_a;
  logic [cgcs_pkg::PITCH_W-1:0]  mul_b;
  logic [cgcs_pkg::PROD_W-1:0]   mul_p;
  logic                          acc_upd;
  logic                          emit;
  logic                          out_free;
  cgcs_pkg::div_req_t            div_req;
  cgcs_pkg::div_rsp_t            div_rsp;

  logic                          in_fired;
  logic                          muon;
  logic [cgcs_pkg::MOMENT_W:0]   mom_sum;
  logic [cgcs_pkg::TOTAL_W:0]    charge_sum;

  cgcs_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .regs_o (cfg)
  );

  cgcs_mul u_mul (
    .clk  (clk),
    .en_i (mul_en),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  cgcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // A channel fires when it lies inside the grid and reaches the threshold.
  assign in_fired = (7'(in_ch.row) < 7'(cgcs_pkg::GRID_ROWS)) &&
                    (7'(in_ch.col) < 7'(cgcs_pkg::GRID_COLS)) &&
                    (in_ch.charge >= cfg.fire_threshold);

  assign in_ch.ready = (state_r == cgcs_pkg::ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    case (state_r)
      cgcs_pkg::ST_IDLE: begin
        axis_nxt = 1'b0;
        if (in_take) begin
          if (in_fired) begin
            state_nxt = cgcs_pkg::ST_MUL_PITCH;
          end else if (in_ch.last_channel) begin
            state_nxt = in_ch.timestamp_error ? cgcs_pkg::ST_EMIT
                                              : cgcs_pkg::ST_DIV_START;
          end
        end
      end
      cgcs_pkg::ST_MUL_PITCH: begin
        state_nxt = cgcs_pkg::ST_MUL_POS;
      end
      cgcs_pkg::ST_MUL_POS: begin
        state_nxt = cgcs_pkg::ST_ACCUM;
      end
      cgcs_pkg::ST_ACCUM: begin
        axis_nxt = !axis_r;
        if (!axis_r) begin
          state_nxt = cgcs_pkg::ST_MUL_PITCH;
        end else if (last_r) begin
          state_nxt = ts_err_r ? cgcs_pkg::ST_EMIT : cgcs_pkg::ST_DIV_START;
        end else begin
          state_nxt = cgcs_pkg::ST_IDLE;
        end
      end
      cgcs_pkg::ST_DIV_START: begin
        state_nxt = cgcs_pkg::ST_DIV_WAIT;
      end
      cgcs_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (!axis_r) begin
            axis_nxt  = 1'b1;
            state_nxt = cgcs_pkg::ST_DIV_START;
          end else begin
            state_nxt = cgcs_pkg::ST_EMIT;
          end
        end
      end
      cgcs_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = cgcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cgcs_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs: operand steering for the shared units.
  always_comb begin
    mul_en           = 1'b0;
    mul_a            = {{(cgcs_pkg::MUL_A_W-cgcs_pkg::CHARGE_W){1'b0}}, charge_r};
    mul_b            = axis_r ? cfg.pitch_col : cfg.pitch_row;
    acc_upd          = 1'b0;
    emit             = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = axis_r ? col_mom_r[cgcs_pkg::MOMENT_W-1:5]
                              : row_mom_r[cgcs_pkg::MOMENT_W-1:5];
    div_req.divisor  = charge_acc_r;
    case (state_r)
      cgcs_pkg::ST_MUL_PITCH: begin
        mul_en = 1'b1;
      end
      cgcs_pkg::ST_MUL_POS: begin
        // Position weight 2 * index + 1, in half-pitch units.
        mul_en = 1'b1;
        mul_a  = mul_p[cgcs_pkg::MUL_A_W-1:0];
        mul_b  = {{(cgcs_pkg::PITCH_W-cgcs_pkg::IDX_W-1){1'b0}},
                  (axis_r ? col_r : row_r), 1'b1};
      end
      cgcs_pkg::ST_ACCUM: begin
        acc_upd = 1'b1;
      end
      cgcs_pkg::ST_DIV_START: begin
        div_req.start = 1'b1;
      end
      cgcs_pkg::ST_EMIT: begin
        emit = out_free;
      end
      default: ;
    endcase
  end

  // Accumulator next values, with saturation on every sum.
  assign mom_sum    = {1'b0, (axis_r ? col_mom_r : row_mom_r)} +
                      (cgcs_pkg::MOMENT_W+1)'(mul_p);
  assign charge_sum = {1'b0, charge_acc_r} + (cgcs_pkg::TOTAL_W+1)'(charge_r);

  always_comb begin
    fired_acc_nxt  = fired_acc_r;
    charge_acc_nxt = charge_acc_r;
    row_mom_nxt    = row_mom_r;
    col_mom_nxt    = col_mom_r;
    max_seen_nxt   = max_seen_r;
    max_row_nxt    = max_row_r;
    max_col_nxt    = max_col_r;
    if (emit) begin
      fired_acc_nxt  = '0;
      charge_acc_nxt = '0;
      row_mom_nxt    = '0;
      col_mom_nxt    = '0;
      max_seen_nxt   = '0;
      max_row_nxt    = '0;
      max_col_nxt    = '0;
    end else if (acc_upd) begin
      if (!axis_r) begin
        if (fired_acc_r != cgcs_pkg::FIRED_MAX) begin
          fired_acc_nxt = fired_acc_r + 1'b1;
        end
        charge_acc_nxt = charge_sum[cgcs_pkg::TOTAL_W] ? '1
                                                       : charge_sum[cgcs_pkg::TOTAL_W-1:0];
        row_mom_nxt    = mom_sum[cgcs_pkg::MOMENT_W] ? '1
                                                     : mom_sum[cgcs_pkg::MOMENT_W-1:0];
        // Strictly greater keeps the first maximum on ties.
        if (charge_r > max_seen_r) begin
          max_seen_nxt = charge_r;
          max_row_nxt  = row_r;
          max_col_nxt  = col_r;
        end
      end else begin
        col_mom_nxt = mom_sum[cgcs_pkg::MOMENT_W] ? '1
                                                  : mom_sum[cgcs_pkg::MOMENT_W-1:0];
      end
    end
  end

  assign muon = (charge_acc_r > cfg.muon_charge_low) &&
                (charge_acc_r < cfg.muon_charge_high) &&
                (fired_acc_r > cfg.muon_fired_low) &&
                (fired_acc_r < cfg.muon_fired_high);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cgcs_pkg::ST_IDLE;
      axis_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      fired_acc_r  <= '0;
      charge_acc_r <= '0;
      row_mom_r    <= '0;
      col_mom_r    <= '0;
      max_seen_r   <= '0;
      max_row_r    <= '0;
      max_col_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      axis_r       <= axis_nxt;
      fired_acc_r  <= fired_acc_nxt;
      charge_acc_r <= charge_acc_nxt;
      row_mom_r    <= row_mom_nxt;
      col_mom_r    <= col_mom_nxt;
      max_seen_r   <= max_seen_nxt;
      max_row_r    <= max_row_nxt;
      max_col_r    <= max_col_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: input latch, centroids and the output summary.
  always_ff @(posedge clk) begin
    if (in_take) begin
      charge_r <= in_ch.charge;
      row_r    <= in_ch.row;
      col_r    <= in_ch.col;
      last_r   <= in_ch.last_channel;
      board_r  <= in_ch.board_ok;
      ts_err_r <= in_ch.timestamp_error;
    end
    if (state_r == cgcs_pkg::ST_DIV_WAIT && div_rsp.done) begin
      if (axis_r) begin
        cent_col_r <= div_rsp.quot;
      end else begin
        cent_row_r <= div_rsp.quot;
      end
    end
    if (emit) begin
      o_type_r <= board_r;
      if (ts_err_r) begin
        // Bad event: everything but the event type reads zero.
        o_good_r     <= 1'b0;
        o_fired_r    <= '0;
        o_total_r    <= '0;
        o_max_r      <= '0;
        o_max_row_r  <= '0;
        o_max_col_r  <= '0;
        o_cent_row_r <= '0;
        o_cent_col_r <= '0;
        o_muon_r     <= 1'b0;
      end else begin
        o_good_r     <= 1'b1;
        o_fired_r    <= fired_acc_r;
        o_total_r    <= charge_acc_r;
        o_max_r      <= max_seen_r;
        o_max_row_r  <= max_row_r;
        o_max_col_r  <= max_col_r;
        o_cent_row_r <= cent_row_r;
        o_cent_col_r <= cent_col_r;
        o_muon_r     <= muon;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.event_type     = o_type_r;
  assign out_ch.event_good     = o_good_r;
  assign out_ch.fired_count    = o_fired_r;
  assign out_ch.total_charge   = o_total_r;
  assign out_ch.max_charge     = o_max_r;
  assign out_ch.max_row        = o_max_row_r;
  assign out_ch.max_col        = o_max_col_r;
  assign out_ch.centroid_row   = o_cent_row_r;
  assign out_ch.centroid_col   = o_cent_col_r;
  assign out_ch.muon_candidate = o_muon_r;

endmodule
